// ===== src/fslc_pkg.sv =====
// ----------------------------------------------------------------------------
// fslc_pkg
// Shared types and constants for the floor-sum / lattice-count engine.
// ----------------------------------------------------------------------------
package fslc_pkg;

  localparam int unsigned ArgWidthDef    = 31;
  localparam int unsigned ResultWidthDef = 64;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NOP,
    OP_SET_BAD,
    OP_SDIV,
    OP_SMUL0,
    OP_SMUL1,
    OP_SSETUP,
    OP_SWAP,
    OP_DIVK,
    OP_DIVC,
    OP_MULRK,
    OP_DIVT,
    OP_MULQK,
    OP_ADD_U,
    OP_SUB_S,
    OP_DIVZ,
    OP_MULTRI,
    OP_MULKT,
    OP_MULZS,
    OP_ACC_ADD,
    OP_ACC_SUB,
    OP_MULUB,
    OP_SUB_C,
    OP_MULKB,
    OP_ROT
  } op_e;

  typedef struct packed {
    logic load;
    op_e  op;
  } dp_cmd_t;

  typedef struct packed {
    logic cmd;
    logic sum_gt;
    logic a_zero;
    logic b_zero;
    logic c_zero;
    logic mdu_done;
  } dp_status_t;

  // Operation runs on the shared multiply/divide unit
  function automatic logic is_long(op_e op);
    case (op)
      OP_SDIV, OP_SMUL0, OP_SMUL1, OP_DIVK, OP_DIVC, OP_MULRK, OP_DIVT,
      OP_MULQK, OP_DIVZ, OP_MULTRI, OP_MULKT, OP_MULZS, OP_MULUB,
      OP_MULKB: is_long = 1'b1;
      default:  is_long = 1'b0;
    endcase
  endfunction

  // Operation uses the divider side of the unit
  function automatic logic is_div(op_e op);
    case (op)
      OP_SDIV, OP_DIVK, OP_DIVC, OP_DIVT, OP_DIVZ: is_div = 1'b1;
      default:                                      is_div = 1'b0;
    endcase
  endfunction

endpackage

// ===== src/fslc_mdu.sv =====
// ----------------------------------------------------------------------------
// fslc_mdu
// Shared serial unit: shift-add multiply (mod 2^XW) or restoring divide,
// one bit per cycle.
// ----------------------------------------------------------------------------
module fslc_mdu #(
  parameter int unsigned XW = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          div_i,
  input  logic [XW-1:0] x_i,
  input  logic [XW-1:0] y_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [XW-1:0] lo_o,
  output logic [XW-1:0] hi_o
);

  localparam int unsigned CW = $clog2(XW);

  logic          busy_q, div_q;
  logic [CW-1:0] cnt_q;
  logic [XW-1:0] opa_q, opb_q, acc_q;
  logic [XW-1:0] opa_d, opb_d, acc_d;
  logic [XW:0]   trial;
  logic          ge;

  // Compute one step of the active operation
  always_comb begin
    trial = {acc_q, opa_q[XW-1]};
    ge    = trial >= {1'b0, opb_q};
    if (div_q) begin
      acc_d = ge ? XW'(trial - {1'b0, opb_q}) : trial[XW-1:0];
      opa_d = {opa_q[XW-2:0], ge};
      opb_d = opb_q;
    end else begin
      acc_d = opb_q[0] ? acc_q + opa_q : acc_q;
      opa_d = {opa_q[XW-2:0], 1'b0};
      opb_d = {1'b0, opb_q[XW-1:1]};
    end
  end

  assign done_o = busy_q && (div_q ? (cnt_q == CW'(XW - 1)) : (opb_q[XW-1:1] == '0));
  assign busy_o = busy_q;
  assign lo_o   = div_q ? opa_d : acc_d;
  assign hi_o   = acc_d;

  // Track run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (done_o) busy_q <= 1'b0;
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Load operands or advance one bit
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      div_q <= div_i;
      opa_q <= x_i;
      opb_q <= y_i;
      acc_q <= '0;
    end else if (busy_q) begin
      opa_q <= opa_d;
      opb_q <= opb_d;
      acc_q <= acc_d;
    end
  end

endmodule

// ===== src/fslc_datapath.sv =====
// ----------------------------------------------------------------------------
// fslc_datapath
// Working registers of the Euclid-like reduction and the running total.
// ----------------------------------------------------------------------------
module fslc_datapath #(
  parameter int unsigned ARG_WIDTH    = fslc_pkg::ArgWidthDef,
  parameter int unsigned RESULT_WIDTH = fslc_pkg::ResultWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fslc_pkg::dp_cmd_t        cmd_i,
  input  logic                     cmd_in_i,
  input  logic [ARG_WIDTH-1:0]     coef_a_i,
  input  logic [ARG_WIDTH-1:0]     coef_b_i,
  input  logic [ARG_WIDTH-1:0]     bound_c_i,
  input  logic [ARG_WIDTH-1:0]     term_count_i,
  output fslc_pkg::dp_status_t     status_o,
  output logic [RESULT_WIDTH-1:0]  total_o,
  output logic                     bad_o
);

  localparam int unsigned WW = 2 * ARG_WIDTH + 2;
  localparam int unsigned XW = (WW > RESULT_WIDTH) ? WW : RESULT_WIDTH;

  logic [XW-1:0] ra_q, rb_q, rc_q, rn_q, rk_q, rq_q, rr_q, rt_q, ru_q, rs_q, rz_q;
  logic [RESULT_WIDTH-1:0] tot_q;
  logic          bad_q, cmd_q;
  logic [XW-1:0] mx, my, lo, hi, zp1, tri_x, tri_y;
  logic          start, busy, done;
  fslc_pkg::op_e op;

  assign op    = cmd_i.op;
  assign zp1   = rz_q + XW'(1);
  assign tri_x = rz_q[0] ? {1'b0, zp1[XW-1:1]} : {1'b0, rz_q[XW-1:1]};
  assign tri_y = rz_q[0] ? rz_q : zp1;
  assign start = fslc_pkg::is_long(op) && !busy;

  // Route operands to the shared unit
  always_comb begin
    case (op)
      fslc_pkg::OP_SDIV:   begin mx = ra_q;  my = rc_q;  end
      fslc_pkg::OP_SMUL0:  begin mx = rq_q;  my = rn_q;  end
      fslc_pkg::OP_SMUL1:  begin mx = rn_q + XW'(1); my = rb_q; end
      fslc_pkg::OP_DIVK:   begin mx = ra_q;  my = rb_q;  end
      fslc_pkg::OP_DIVC:   begin mx = rc_q;  my = ra_q;  end
      fslc_pkg::OP_MULRK:  begin mx = rr_q;  my = rk_q;  end
      fslc_pkg::OP_DIVT:   begin mx = rt_q;  my = ra_q;  end
      fslc_pkg::OP_MULQK:  begin mx = rq_q;  my = rk_q;  end
      fslc_pkg::OP_DIVZ:   begin mx = rs_q;  my = rk_q;  end
      fslc_pkg::OP_MULTRI: begin mx = tri_x; my = tri_y; end
      fslc_pkg::OP_MULKT:  begin mx = rk_q;  my = rt_q;  end
      fslc_pkg::OP_MULZS:  begin mx = zp1;   my = rs_q;  end
      fslc_pkg::OP_MULUB:  begin mx = ru_q;  my = rb_q;  end
      fslc_pkg::OP_MULKB:  begin mx = rk_q;  my = rb_q;  end
      default:             begin mx = '0;    my = '0;    end
    endcase
  end

  fslc_mdu #(.XW(XW)) u_mdu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .div_i   (fslc_pkg::is_div(op)),
    .x_i     (mx),
    .y_i     (my),
    .busy_o  (busy),
    .done_o  (done),
    .lo_o    (lo),
    .hi_o    (hi)
  );

  // Load a request, apply short ops, write back unit results
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= cmd_in_i;
      ra_q  <= XW'(coef_a_i);
      rb_q  <= XW'(coef_b_i);
      rc_q  <= XW'(bound_c_i);
      rn_q  <= XW'(term_count_i);
      tot_q <= '0;
      bad_q <= 1'b0;
    end else begin
      case (op)
        fslc_pkg::OP_SET_BAD: bad_q <= 1'b1;
        fslc_pkg::OP_SSETUP: begin
          rc_q <= rt_q + rr_q;
          ra_q <= rb_q;
          rb_q <= rc_q;
        end
        fslc_pkg::OP_SWAP: begin
          if (ra_q < rb_q) begin
            ra_q <= rb_q;
            rb_q <= ra_q;
          end
        end
        fslc_pkg::OP_ADD_U:   ru_q  <= ru_q + rt_q;
        fslc_pkg::OP_SUB_S:   rs_q  <= ru_q - rk_q;
        fslc_pkg::OP_ACC_ADD: tot_q <= tot_q + rq_q[RESULT_WIDTH-1:0];
        fslc_pkg::OP_ACC_SUB: tot_q <= tot_q - rt_q[RESULT_WIDTH-1:0];
        fslc_pkg::OP_SUB_C:   rc_q  <= rc_q - ru_q;
        fslc_pkg::OP_ROT: begin
          ra_q <= rb_q;
          rb_q <= ra_q - rt_q;
        end
        default: begin
          if (done) begin
            case (op)
              fslc_pkg::OP_SDIV:   begin rq_q <= lo; rr_q <= hi; end
              fslc_pkg::OP_SMUL0:  tot_q <= lo[RESULT_WIDTH-1:0];
              fslc_pkg::OP_SMUL1:  rt_q <= lo;
              fslc_pkg::OP_DIVK:   rk_q <= lo;
              fslc_pkg::OP_DIVC:   begin rq_q <= lo; rr_q <= hi; end
              fslc_pkg::OP_MULRK:  rt_q <= lo;
              fslc_pkg::OP_DIVT:   rt_q <= lo;
              fslc_pkg::OP_MULQK:  ru_q <= lo;
              fslc_pkg::OP_DIVZ:   rz_q <= lo;
              fslc_pkg::OP_MULTRI: rt_q <= lo;
              fslc_pkg::OP_MULKT:  rt_q <= lo;
              fslc_pkg::OP_MULZS:  rq_q <= lo;
              fslc_pkg::OP_MULUB:  ru_q <= lo;
              fslc_pkg::OP_MULKB:  rt_q <= lo;
              default: ;
            endcase
          end
        end
      endcase
    end
  end

  // Report flags to the controller
  always_comb begin
    status_o.cmd      = cmd_q;
    status_o.sum_gt   = ({1'b0, ra_q} + {1'b0, rb_q}) > {1'b0, rc_q};
    status_o.a_zero   = (ra_q == '0);
    status_o.b_zero   = (rb_q == '0);
    status_o.c_zero   = (rc_q == '0);
    status_o.mdu_done = done;
  end

  assign total_o = tot_q;
  assign bad_o   = bad_q;

endmodule

// ===== src/fslc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fslc_ctrl
// Sequencer for setup, the reduction rounds and the result handshake.
// ----------------------------------------------------------------------------
module fslc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  fslc_pkg::dp_status_t status_i,
  output fslc_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_BAD, S_SDIV, S_SMUL0, S_SMUL1, S_SSETUP, S_TEST,
    S_SWAP, S_BZ, S_DIVK, S_DIVC, S_MULRK, S_DIVT, S_MULQK, S_ADDU, S_SUBS,
    S_DIVZ, S_MULTRI, S_MULKT, S_MULZS, S_ACCA, S_ACCS, S_MULUB, S_SUBC,
    S_MULKB, S_ROT, S_OUT
  } state_e;

  state_e state_q;
  logic   in_ready_q, out_valid_q;

  // Map state to datapath operation
  always_comb begin
    cmd_o.load = in_valid_i && in_ready_q;
    case (state_q)
      S_BAD:    cmd_o.op = fslc_pkg::OP_SET_BAD;
      S_SDIV:   cmd_o.op = fslc_pkg::OP_SDIV;
      S_SMUL0:  cmd_o.op = fslc_pkg::OP_SMUL0;
      S_SMUL1:  cmd_o.op = fslc_pkg::OP_SMUL1;
      S_SSETUP: cmd_o.op = fslc_pkg::OP_SSETUP;
      S_SWAP:   cmd_o.op = fslc_pkg::OP_SWAP;
      S_DIVK:   cmd_o.op = fslc_pkg::OP_DIVK;
      S_DIVC:   cmd_o.op = fslc_pkg::OP_DIVC;
      S_MULRK:  cmd_o.op = fslc_pkg::OP_MULRK;
      S_DIVT:   cmd_o.op = fslc_pkg::OP_DIVT;
      S_MULQK:  cmd_o.op = fslc_pkg::OP_MULQK;
      S_ADDU:   cmd_o.op = fslc_pkg::OP_ADD_U;
      S_SUBS:   cmd_o.op = fslc_pkg::OP_SUB_S;
      S_DIVZ:   cmd_o.op = fslc_pkg::OP_DIVZ;
      S_MULTRI: cmd_o.op = fslc_pkg::OP_MULTRI;
      S_MULKT:  cmd_o.op = fslc_pkg::OP_MULKT;
      S_MULZS:  cmd_o.op = fslc_pkg::OP_MULZS;
      S_ACCA:   cmd_o.op = fslc_pkg::OP_ACC_ADD;
      S_ACCS:   cmd_o.op = fslc_pkg::OP_ACC_SUB;
      S_MULUB:  cmd_o.op = fslc_pkg::OP_MULUB;
      S_SUBC:   cmd_o.op = fslc_pkg::OP_SUB_C;
      S_MULKB:  cmd_o.op = fslc_pkg::OP_MULKB;
      S_ROT:    cmd_o.op = fslc_pkg::OP_ROT;
      default:  cmd_o.op = fslc_pkg::OP_NOP;
    endcase
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  // Advance the sequence; long ops hold until the unit finishes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_CHECK;
            in_ready_q <= 1'b0;
          end
        end
        S_CHECK: begin
          if (!status_i.cmd) begin
            if (status_i.sum_gt) begin
              state_q     <= S_OUT;
              out_valid_q <= 1'b1;
            end else if (status_i.a_zero || status_i.b_zero) begin
              state_q <= S_BAD;
            end else begin
              state_q <= S_SWAP;
            end
          end else if (status_i.c_zero) begin
            state_q <= S_BAD;
          end else begin
            state_q <= S_SDIV;
          end
        end
        S_BAD: begin
          state_q     <= S_OUT;
          out_valid_q <= 1'b1;
        end
        S_SDIV:   if (status_i.mdu_done) state_q <= S_SMUL0;
        S_SMUL0:  if (status_i.mdu_done) state_q <= S_SMUL1;
        S_SMUL1:  if (status_i.mdu_done) state_q <= S_SSETUP;
        S_SSETUP: state_q <= S_TEST;
        S_TEST: begin
          if (status_i.sum_gt) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= S_SWAP;
          end
        end
        S_SWAP: state_q <= S_BZ;
        S_BZ: begin
          if (status_i.b_zero) begin
            state_q     <= S_OUT;
            out_valid_q <= 1'b1;
          end else begin
            state_q <= S_DIVK;
          end
        end
        S_DIVK:   if (status_i.mdu_done) state_q <= S_DIVC;
        S_DIVC:   if (status_i.mdu_done) state_q <= S_MULRK;
        S_MULRK:  if (status_i.mdu_done) state_q <= S_DIVT;
        S_DIVT:   if (status_i.mdu_done) state_q <= S_MULQK;
        S_MULQK:  if (status_i.mdu_done) state_q <= S_ADDU;
        S_ADDU:   state_q <= S_SUBS;
        S_SUBS:   state_q <= S_DIVZ;
        S_DIVZ:   if (status_i.mdu_done) state_q <= S_MULTRI;
        S_MULTRI: if (status_i.mdu_done) state_q <= S_MULKT;
        S_MULKT:  if (status_i.mdu_done) state_q <= S_MULZS;
        S_MULZS:  if (status_i.mdu_done) state_q <= S_ACCA;
        S_ACCA:   state_q <= S_ACCS;
        S_ACCS:   state_q <= S_MULUB;
        S_MULUB:  if (status_i.mdu_done) state_q <= S_SUBC;
        S_SUBC:   state_q <= S_MULKB;
        S_MULKB:  if (status_i.mdu_done) state_q <= S_ROT;
        S_ROT:    state_q <= S_TEST;
        S_OUT: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/floor_sum_lattice_count_core.sv =====
// Trivial requests finish after the check, bad ones after the bad-flag step.
// Otherwise a summation request first runs a setup of one division and two
// multiplications, and each reduction round runs four divisions, seven
// multiplications and nine register steps; XW = max(2*ARG_WIDTH+2, RESULT_WIDTH).
// Throughput: one request at a time; the next is taken only after the result is accepted.
// Reset: asynchronous active low; the block comes up idle and ready.
// ----------------------------------------------------------------------------
// floor_sum_lattice_count_core
// Lattice-point count and floor summation by Euclid-like reduction.
// ----------------------------------------------------------------------------
module floor_sum_lattice_count_core #(
  parameter int unsigned ARG_WIDTH    = fslc_pkg::ArgWidthDef,
  parameter int unsigned RESULT_WIDTH = fslc_pkg::ResultWidthDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [ARG_WIDTH-1:0]    coef_a_i,
  input  logic [ARG_WIDTH-1:0]    coef_b_i,
  input  logic [ARG_WIDTH-1:0]    bound_c_i,
  input  logic [ARG_WIDTH-1:0]    term_count_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [RESULT_WIDTH-1:0] total_o,
  output logic                    bad_input_o
);

  fslc_pkg::dp_cmd_t    dp_cmd;
  fslc_pkg::dp_status_t dp_status;

  fslc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  fslc_datapath #(
    .ARG_WIDTH    (ARG_WIDTH),
    .RESULT_WIDTH (RESULT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (dp_cmd),
    .cmd_in_i     (cmd_i),
    .coef_a_i     (coef_a_i),
    .coef_b_i     (coef_b_i),
    .bound_c_i    (bound_c_i),
    .term_count_i (term_count_i),
    .status_o     (dp_status),
    .total_o      (total_o),
    .bad_o        (bad_input_o)
  );

  // Never ready for a new beat while a result is shown
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");

  // A bad request reports a zero total
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_input_o) |-> (total_o == '0))
    else $error("bad request with nonzero total");

  // An accepted beat closes the input side
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input still ready after accept");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the floor-sum / lattice-count engine: directed edge
// requests, then random counts and sums, checked beat by beat against an
// in-bench 128-bit Euclid-reduction predictor, with random stalls both sides.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned AW = fslc_pkg::ArgWidthDef;
  localparam int unsigned RW = fslc_pkg::ResultWidthDef;
  localparam logic        CMD_COUNT = 1'b0;
  localparam logic        CMD_SUM   = 1'b1;
  localparam logic [AW-1:0] ARG_MAX = '1;

  typedef struct {
    logic [RW-1:0] total;
    logic          bad;
  } answer_t;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  logic          cmd_i;
  logic [AW-1:0] coef_a_i;
  logic [AW-1:0] coef_b_i;
  logic [AW-1:0] bound_c_i;
  logic [AW-1:0] term_count_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic [RW-1:0] total_o;
  logic          bad_input_o;

  answer_t answer_q[$];
  int      error_cnt;
  int      beats_sent;
  int      beats_checked;
  int      bad_seen;

  floor_sum_lattice_count_core dut (.*);

  // Drive the clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #400000000;
    $display("TB_ERROR");
    $finish;
  end

  // Pick an idle length: mostly none, sometimes short, rarely long
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(80, 10);
  endfunction

  // Count points x,y > 0 with a*x + b*y <= c, total modulo 2^64
  function automatic logic [63:0] count_points(logic [127:0] a, logic [127:0] b,
                                               logic [127:0] c);
    logic [63:0]  acc;
    logic [127:0] k, u, s, z, z1, tri_v, nb, tmp;
    acc = '0;
    forever begin
      if (a + b > c) break;
      if (a < b) begin
        tmp = a;
        a = b;
        b = tmp;
      end
      if (b == 0) break;
      k = a / b;
      u = (c * k) / a;
      // add (u-k) + (u-2k) + ... over non-negative terms
      s  = u - k;
      z  = s / k;
      z1 = z + 128'(1);
      if (z[0] == 1'b0) tri_v = (z >> 1) * z1;
      else tri_v = (z1 >> 1) * z;
      acc += z1[63:0] * s[63:0] - k[63:0] * tri_v[63:0];
      c  = c - u * b;
      nb = a - k * b;
      a  = b;
      b  = nb;
    end
    return acc;
  endfunction

  function automatic answer_t predict_answer(logic cmd, logic [AW-1:0] a,
                                             logic [AW-1:0] b, logic [AW-1:0] c,
                                             logic [AW-1:0] n);
    answer_t      ans;
    logic [127:0] aw, bw, cw, nw;
    aw = 128'(a);
    bw = 128'(b);
    cw = 128'(c);
    nw = 128'(n);
    ans.total = '0;
    ans.bad   = 1'b0;
    if (cmd == CMD_COUNT) begin
      if (aw + bw <= cw) begin
        if (a == 0 || b == 0) ans.bad = 1'b1;
        else ans.total = count_points(aw, bw, cw);
      end
    end else if (c == 0) begin
      ans.bad = 1'b1;
    end else begin
      ans.total = RW'((aw / cw) * nw);
      ans.total += count_points(bw, cw, (nw + 128'(1)) * bw + (aw % cw));
    end
    return ans;
  endfunction

  // Send one request beat; called at a falling edge, returns at one
  task automatic send_request(logic cmd, logic [AW-1:0] a, logic [AW-1:0] b,
                              logic [AW-1:0] c, logic [AW-1:0] n);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    coef_a_i     <= a;
    coef_b_i     <= b;
    bound_c_i    <= c;
    term_count_i <= n;
    answer_q.push_back(predict_answer(cmd, a, b, c, n));
    #0;
    while (!in_ready_o) @(negedge clk_i);
    // ready seen high before the rising edge: the beat moves there
    @(negedge clk_i);
    beats_sent++;
  endtask

  // Random argument, mostly small to keep the reduction short
  function automatic logic [AW-1:0] rand_arg();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 60) return AW'($urandom_range(300));
    if (roll < 85) return AW'($urandom_range(1 << 16));
    return AW'($urandom);
  endfunction

  task automatic test_count_edges();
    send_request(CMD_COUNT, '0, '0, '0, '0);
    send_request(CMD_COUNT, 5, 0, 3, ARG_MAX);
    send_request(CMD_COUNT, 0, 3, 10, 0);
    send_request(CMD_COUNT, 7, 0, 100, 0);
    send_request(CMD_COUNT, ARG_MAX, ARG_MAX, ARG_MAX, ARG_MAX);
    send_request(CMD_COUNT, 1, 1, ARG_MAX, 0);
    send_request(CMD_COUNT, 1, 1, 2, 0);
    send_request(CMD_COUNT, 3, 5, 40, 0);
    // consecutive Fibonacci numbers drive the longest reduction
    send_request(CMD_COUNT, 1836311903, 1134903170, ARG_MAX, 0);
    send_request(CMD_COUNT, 1, ARG_MAX - 1, ARG_MAX, 0);
  endtask

  task automatic test_sum_edges();
    send_request(CMD_SUM, 10, 3, 0, 5);
    send_request(CMD_SUM, '0, '0, '0, '0);
    send_request(CMD_SUM, 100, 0, 7, 50);
    send_request(CMD_SUM, 100, 7, 3, 0);
    send_request(CMD_SUM, ARG_MAX, ARG_MAX, 1, ARG_MAX);
    send_request(CMD_SUM, ARG_MAX, ARG_MAX, ARG_MAX, ARG_MAX);
    send_request(CMD_SUM, 0, 1, 1, 1);
    send_request(CMD_SUM, 5, 1134903170, 1836311903, ARG_MAX);
    send_request(CMD_SUM, 1, 2, 3, 10);
  endtask

  task automatic test_random_count(int num);
    repeat (num) send_request(CMD_COUNT, rand_arg(), rand_arg(), rand_arg(), AW'($urandom));
  endtask

  task automatic test_random_sum(int num);
    repeat (num) send_request(CMD_SUM, rand_arg(), rand_arg(), rand_arg(), rand_arg());
  endtask

  task automatic test_random_mixed(int num);
    repeat (num) send_request(1'($urandom), rand_arg(), rand_arg(), rand_arg(), rand_arg());
  endtask

  // Result side: pick ready at the falling edge, check the beat at the rising edge
  initial begin
    int      stall;
    logic    rdy;
    answer_t exp_ans;
    stall = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        rdy = 1'b0;
        stall--;
      end else begin
        rdy = 1'b1;
        stall = pick_gap();
      end
      out_ready_i <= rdy;
      @(posedge clk_i);
      if (out_ready_i && out_valid_o) begin
        if (answer_q.size() == 0) begin
          $display("%0t: result beat with nothing pending: total=%0h bad=%0b",
                   $time, total_o, bad_input_o);
          error_cnt++;
        end else begin
          exp_ans = answer_q.pop_front();
          if (total_o !== exp_ans.total) begin
            $display("%0t: total mismatch: expected %0h actual %0h",
                     $time, exp_ans.total, total_o);
            error_cnt++;
          end
          if (bad_input_o !== exp_ans.bad) begin
            $display("%0t: bad_input mismatch: expected %0b actual %0b",
                     $time, exp_ans.bad, bad_input_o);
            error_cnt++;
          end
          if (bad_input_o) bad_seen++;
          beats_checked++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    int drain;
    error_cnt     = 0;
    beats_sent    = 0;
    beats_checked = 0;
    bad_seen      = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    cmd_i         = 1'b0;
    coef_a_i      = '0;
    coef_b_i      = '0;
    bound_c_i     = '0;
    term_count_i  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_count_edges();
    test_sum_edges();
    test_random_count(90);
    test_random_sum(90);
    test_random_mixed(100);
    in_valid_i <= 1'b0;

    // Drain pending results, then idle out the tail
    drain = 0;
    while (answer_q.size() != 0 && drain < 5000000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (200) @(negedge clk_i);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, answer_q.size());
      error_cnt++;
    end

    $display("Covered %0d requests (counts, sums, zero and max operands), %0d results checked,",
             beats_sent, beats_checked);
    $display("%0d of them flagged as bad input.", bad_seen);
    if (error_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fslc_pkg.sv
src/fslc_mdu.sv
src/fslc_datapath.sv
src/fslc_ctrl.sv
src/floor_sum_lattice_count_core.sv
dv/tb_top.sv
